/* src/smpq_pkg.sv */
// smpq_pkg: sizes, codes and payload types for the sorted max priority queue
// used by smpq_cell and sorted_max_priority_queue_unit; no dependencies

package smpq_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_BITS  = 32;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      op_type                      operation;
      logic signed [DATA_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] popped_value;
      status_type                  status;
      logic [COUNT_BITS-1:0]       entry_count;
   } rsp_type;

   // broadcast to every cell of the chain for one transfer
   typedef struct packed {
      logic                        insert;
      logic                        pop;
      logic signed [DATA_BITS-1:0] value;
   } cell_ctrl_type;

endpackage

/* src/smpq_cell.sv */
// smpq_cell: one entry of the sorted chain with its compare-and-shift logic
// depends on smpq_pkg

module smpq_cell (
   input  logic                                  clock,
   input  smpq_pkg::cell_ctrl_type               ctrl,
   input  logic                                  occupied,
   input  logic signed [smpq_pkg::DATA_BITS-1:0] prev_data,
   input  logic                                  prev_move,
   input  logic signed [smpq_pkg::DATA_BITS-1:0] next_data,
   output logic signed [smpq_pkg::DATA_BITS-1:0] data,
   output logic                                  move
);
   import smpq_pkg::*;

   logic signed [DATA_BITS-1:0] data_ff;
   logic signed [DATA_BITS-1:0] data_in;

   // true where the new value goes here or ahead: empty slot or entry not larger
   assign move = !occupied || (data_ff <= ctrl.value);
   assign data = data_ff;

   always_comb begin
      data_in = data_ff;
      priority if (ctrl.insert) begin
         priority if (prev_move) begin
            data_in = prev_data;
         end else if (move) begin
            data_in = ctrl.value;
         end else begin
            data_in = data_ff;
         end
      end else if (ctrl.pop) begin
         data_in = next_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

/* src/sorted_max_priority_queue_unit.sv */
// sorted_max_priority_queue_unit: top level of the sorted max priority queue
// depends on smpq_pkg and smpq_cell

// Holds up to DEPTH signed values in a chain of cells kept in descending order.
// Every cell compares its entry with the incoming value in parallel and shifts
// in the same cycle, so busy never rises: a new item can be started every
// cycle. The result of an item is shown with rsp_strobe in the cycle after
// start is taken and must be captured then, since the receiver cannot stall it.
// A pop on an empty queue returns zero with status empty; an insert into a full
// queue is dropped with status full.

module sorted_max_priority_queue_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  smpq_pkg::req_type req_item,
   output logic              rsp_strobe,
   output smpq_pkg::rsp_type rsp_item
);
   import smpq_pkg::*;

   logic [COUNT_BITS-1:0]       count_ff;
   logic [COUNT_BITS-1:0]       count_in;
   logic                        rsp_strobe_ff;
   rsp_type                     rsp_item_ff;
   rsp_type                     rsp_item_in;
   logic                        accept;
   logic                        is_full;
   logic                        is_empty;
   cell_ctrl_type               ctrl;
   logic [DEPTH-1:0]            occupied;
   logic [DEPTH-1:0]            move;
   logic signed [DATA_BITS-1:0] cell_data [DEPTH];

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_full  = (count_ff == COUNT_BITS'(DEPTH));
   assign is_empty = (count_ff == '0);

   assign ctrl.insert = accept && (req_item.operation == OP_INSERT) && !is_full;
   assign ctrl.pop    = accept && (req_item.operation == OP_POP) && !is_empty;
   assign ctrl.value  = req_item.value;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_BITS-1:0] prev_data;
      logic                        prev_move;
      logic signed [DATA_BITS-1:0] next_data;

      assign occupied[i] = (count_ff > COUNT_BITS'(i));

      if (i == 0) begin : g_head
         assign prev_data = req_item.value;
         assign prev_move = 1'b0;
      end else begin : g_body
         assign prev_data = cell_data[i-1];
         assign prev_move = move[i-1];
      end

      // the tail slot becomes unused on a pop, so any data may enter it
      if (i == DEPTH - 1) begin : g_tail
         assign next_data = cell_data[i];
      end else begin : g_inner
         assign next_data = cell_data[i+1];
      end

      smpq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (occupied[i]),
         .prev_data (prev_data),
         .prev_move (prev_move),
         .next_data (next_data),
         .data      (cell_data[i]),
         .move      (move[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop) begin
         count_in = count_ff - 1'b1;
      end

      rsp_item_in.popped_value = '0;
      rsp_item_in.status       = STATUS_OK;
      rsp_item_in.entry_count  = count_in;
      unique case (req_item.operation)
         OP_INSERT: begin
            if (is_full) begin
               rsp_item_in.status = STATUS_FULL;
            end
         end
         OP_POP: begin
            if (is_empty) begin
               rsp_item_in.status = STATUS_EMPTY;
            end else begin
               rsp_item_in.popped_value = cell_data[0];
            end
         end
         default: begin
            rsp_item_in.status = STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
      if (accept) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

/* sim/tb_sorted_max_priority_queue_unit.sv */
// tb_sorted_max_priority_queue_unit: self-checking bench for the sorted max priority queue
// drives inserts and pops with random gaps, checks each result against a typed row or a shadow store
// depends on smpq_pkg and sorted_max_priority_queue_unit

`timescale 1ns / 100ps

module tb_sorted_max_priority_queue_unit;

   import smpq_pkg::*;

   localparam int RANDOM_ITEMS = 2000;
   localparam int IDLE_LIMIT   = 500;
   localparam int DRAIN_CYCLES = 4;
   localparam int MAX_GAP      = 13;
   localparam int ROW_COUNT    = 16;

   typedef enum {
      PHASE_FILL,
      PHASE_DRAIN,
      PHASE_MIXED
   } phase_type;

   typedef struct packed {
      op_type                      operation;
      logic signed [DATA_BITS-1:0] value;
      logic                        typed;
      logic signed [DATA_BITS-1:0] popped_value;
      status_type                  status;
      logic [COUNT_BITS-1:0]       entry_count;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   rsp_type pending_results [$];

   // shadow copy of the sorted store, largest entry at index 0
   logic signed [DATA_BITS-1:0] shadow_entries [0:DEPTH-1];
   int shadow_fill    = 0;
   int mismatch_count = 0;
   int idle_cycles    = 0;
   int items_sent     = 0;

   // typed rows carry an expectation that reads straight off the spec
   stim_row_type directed_rows [0:ROW_COUNT-1] = '{
      '{OP_POP,    32'hA5A5_A5A5, 1'b1, 32'h0000_0000, STATUS_EMPTY, 7'd0},
      '{OP_INSERT, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, STATUS_OK,    7'd1},
      '{OP_INSERT, 32'h8000_0000, 1'b1, 32'h0000_0000, STATUS_OK,    7'd2},
      '{OP_INSERT, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK,    7'd0},
      '{OP_INSERT, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, STATUS_OK,    7'd0},
      '{OP_INSERT, 32'h0000_0001, 1'b0, 32'h0000_0000, STATUS_OK,    7'd0},
      '{OP_INSERT, 32'h0000_0001, 1'b0, 32'h0000_0000, STATUS_OK,    7'd0},
      '{OP_INSERT, 32'h8000_0000, 1'b0, 32'h0000_0000, STATUS_OK,    7'd0},
      '{OP_POP,    32'h5A5A_5A5A, 1'b1, 32'h7FFF_FFFF, STATUS_OK,    7'd6},
      '{OP_POP,    32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK,    7'd0},
      '{OP_POP,    32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK,    7'd0},
      '{OP_POP,    32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK,    7'd0},
      '{OP_POP,    32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK,    7'd0},
      '{OP_POP,    32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK,    7'd0},
      '{OP_POP,    32'hFFFF_FFFF, 1'b1, 32'h8000_0000, STATUS_OK,    7'd0},
      '{OP_POP,    32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_EMPTY, 7'd0}
   };

   sorted_max_priority_queue_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #5 clock = ~clock;

   // applies one transfer to the shadow store and returns the result it causes
   function automatic rsp_type shadow_queue_step(input req_type item);
      rsp_type                     outcome;
      logic signed [DATA_BITS-1:0] incoming;
      int                          idx;
      outcome.popped_value = '0;
      outcome.status       = STATUS_OK;
      incoming             = item.value;
      if (item.operation == OP_INSERT) begin
         if (shadow_fill >= DEPTH) begin
            outcome.status = STATUS_FULL;
         end else begin
            // new value goes ahead of entries equal to it
            idx = shadow_fill;
            while (idx > 0 && shadow_entries[idx-1] <= incoming) begin
               shadow_entries[idx] = shadow_entries[idx-1];
               idx--;
            end
            shadow_entries[idx] = incoming;
            shadow_fill++;
         end
      end else begin
         if (shadow_fill == 0) begin
            outcome.status = STATUS_EMPTY;
         end else begin
            outcome.popped_value = shadow_entries[0];
            for (idx = 0; idx + 1 < shadow_fill; idx++)
               shadow_entries[idx] = shadow_entries[idx+1];
            shadow_fill--;
         end
      end
      outcome.entry_count = shadow_fill[COUNT_BITS-1:0];
      return outcome;
   endfunction

   function automatic logic signed [DATA_BITS-1:0] draw_value();
      logic signed [DATA_BITS-1:0] picked;
      case ($urandom_range(0, 7))
         0: picked = 32'h7FFF_FFFF;
         1: picked = 32'h8000_0000;
         // narrow range so that equal values show up often
         2, 3: picked = $signed($urandom_range(0, 8)) - 4;
         default: picked = $urandom;
      endcase
      return picked;
   endfunction

   // holds the transfer until taken; the expectation is queued at the negedge before
   task automatic issue(input req_type item, input bit typed, input rsp_type typed_rsp,
                        input int gap);
      rsp_type predicted;
      bit      taken;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         if (!busy) begin
            predicted = shadow_queue_step(item);
            pending_results.push_back(typed ? typed_rsp : predicted);
            taken = 1'b1;
         end
         @(posedge clock);
      end
   endtask

   task automatic issue_random(input op_type op, input bit idle_on);
      req_type item;
      item.operation = op;
      item.value     = draw_value();
      issue(item, 1'b0, '0, idle_on ? $urandom_range(0, MAX_GAP) : 0);
      items_sent++;
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               $error("result with no transfer pending: popped_value %0d status %0d count %0d",
                      rsp_item.popped_value, rsp_item.status, rsp_item.entry_count);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_item.popped_value !== want.popped_value) begin
                  $error("popped_value: expected %0d, actual %0d",
                         want.popped_value, rsp_item.popped_value);
                  mismatch_count++;
               end
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_item.status);
                  mismatch_count++;
               end
               if (rsp_item.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, actual %0d",
                         want.entry_count, rsp_item.entry_count);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      req_type   item;
      rsp_type   typed_rsp;
      phase_type phase;
      bit        idle_on;
      int        extra;
      int        span;
      clock    = 1'b0;
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         item.operation         = directed_rows[r].operation;
         item.value             = directed_rows[r].value;
         typed_rsp.popped_value = directed_rows[r].popped_value;
         typed_rsp.status       = directed_rows[r].status;
         typed_rsp.entry_count  = directed_rows[r].entry_count;
         issue(item, directed_rows[r].typed, typed_rsp,
               (r < 8) ? 0 : $urandom_range(0, MAX_GAP));
      end
      wait_for_results();

      // fill and drain runs reach the full and empty corners; mixed runs are noise
      while (items_sent < RANDOM_ITEMS) begin
         phase   = phase_type'($urandom_range(0, 2));
         idle_on = ($urandom_range(0, 2) != 0);
         case (phase)
            PHASE_FILL: begin
               while (shadow_fill < DEPTH)
                  issue_random(($urandom_range(0, 9) == 0) ? OP_POP : OP_INSERT, idle_on);
               extra = $urandom_range(1, 4);
               repeat (extra) issue_random(OP_INSERT, idle_on);
            end
            PHASE_DRAIN: begin
               while (shadow_fill > 0)
                  issue_random(($urandom_range(0, 9) == 0) ? OP_INSERT : OP_POP, idle_on);
               extra = $urandom_range(1, 4);
               repeat (extra) issue_random(OP_POP, idle_on);
            end
            default: begin
               span = $urandom_range(20, 60);
               repeat (span)
                  issue_random(($urandom_range(0, 1) == 0) ? OP_INSERT : OP_POP, idle_on);
            end
         endcase
         if ($urandom_range(0, 3) == 0) wait_for_results();
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
